FILE: hw/rtl/nv12cb_pkg.sv
package nv12cb_pkg;

  localparam int unsigned ColW     = 13;
  localparam int unsigned RowW     = 12;
  localparam int unsigned DimW     = 13;
  localparam int unsigned StrideW  = 14;
  localparam int unsigned BarW     = 3;
  localparam int unsigned NumW     = 16;

  localparam logic [DimW-1:0]    DefWidth   = 13'd1920;
  localparam logic [DimW-1:0]    DefHeight  = 13'd1080;
  localparam logic [DimW-1:0]    MaxWidth   = 13'd4096;
  localparam logic [DimW-1:0]    MaxRows    = 13'd4096;
  localparam logic [StrideW-1:0] MaxStride  = 14'd8192;
  localparam logic [StrideW-1:0] DefStride  = 14'd1920;
  localparam logic [7:0]         LumaPad    = 8'd16;
  localparam logic [7:0]         ChromaPad  = 8'd128;

  localparam logic [1:0] RegFrameWidth   = 2'd0;
  localparam logic [1:0] RegFrameHeight  = 2'd1;
  localparam logic [1:0] RegLumaStride   = 2'd2;
  localparam logic [1:0] RegChromaStride = 2'd3;

  typedef enum logic [1:0] {
    CompY = 2'd0,
    CompU = 2'd1,
    CompV = 2'd2
  } comp_e;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic            chroma;
    logic            last_col;
    logic            last_row;
  } pos_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       chroma_plane;
    logic       row_end;
    logic       frame_end;
  } res_t;

  function automatic logic [DimW-1:0] eff_width(input logic [DimW-1:0] w);
    logic [DimW-1:0] r;
    r = (w == '0) ? DefWidth : w;
    if (r > MaxWidth) r = MaxWidth;
    return r;
  endfunction

  function automatic logic [DimW-1:0] eff_height(input logic [DimW-1:0] h);
    logic [DimW-1:0] r;
    r = (h == '0) ? DefHeight : h;
    if (r > MaxRows) r = MaxRows;
    return r;
  endfunction

  function automatic logic [StrideW-1:0] eff_stride(input logic [StrideW-1:0] s,
                                                    input logic [DimW-1:0] w);
    logic [StrideW-1:0] r;
    r = (s > MaxStride) ? MaxStride : s;
    if (r < {1'b0, w}) r = {1'b0, w};
    return r;
  endfunction

  function automatic logic [7:0] bar_colour(input logic [BarW-1:0] bar, input comp_e comp);
    logic [7:0] y, u, v;
    case (bar)
      3'd0: begin y = 8'd235; u = 8'd128; v = 8'd128; end
      3'd1: begin y = 8'd210; u = 8'd16;  v = 8'd146; end
      3'd2: begin y = 8'd170; u = 8'd166; v = 8'd16;  end
      3'd3: begin y = 8'd145; u = 8'd54;  v = 8'd34;  end
      3'd4: begin y = 8'd106; u = 8'd202; v = 8'd222; end
      3'd5: begin y = 8'd81;  u = 8'd90;  v = 8'd240; end
      3'd6: begin y = 8'd41;  u = 8'd240; v = 8'd110; end
      default: begin y = 8'd16; u = 8'd128; v = 8'd128; end
    endcase
    case (comp)
      CompU:   return u;
      CompV:   return v;
      default: return y;
    endcase
  endfunction

endpackage

FILE: hw/rtl/nv12cb_counter.sv
module nv12cb_counter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic                            restart_i,
  input  logic [nv12cb_pkg::DimW-1:0]     width_i,
  input  logic [nv12cb_pkg::DimW-1:0]     height_i,
  input  logic [nv12cb_pkg::StrideW-1:0]  luma_stride_i,
  input  logic [nv12cb_pkg::StrideW-1:0]  chroma_stride_i,
  output nv12cb_pkg::pos_t                pos_o
);

  logic [nv12cb_pkg::ColW-1:0] col_q, col_d, col_cur;
  logic [nv12cb_pkg::RowW-1:0] row_q, row_d, row_cur;
  logic                        chroma_q, chroma_d, chroma_cur;
  logic [nv12cb_pkg::StrideW-1:0] stride;
  logic [nv12cb_pkg::DimW-1:0]    rows;
  logic [nv12cb_pkg::StrideW-1:0] col_inc;
  logic [nv12cb_pkg::DimW-1:0]    row_inc;
  logic last_col, last_row;

  always_comb begin
    col_cur    = restart_i ? '0 : col_q;
    row_cur    = restart_i ? '0 : row_q;
    chroma_cur = restart_i ? 1'b0 : chroma_q;
    if (chroma_cur) begin
      stride = nv12cb_pkg::eff_stride(chroma_stride_i, width_i);
      rows   = nv12cb_pkg::DimW'(({1'b0, height_i} + 14'd1) >> 1);
    end else begin
      stride = nv12cb_pkg::eff_stride(luma_stride_i, width_i);
      rows   = height_i;
    end
    col_inc  = {1'b0, col_cur} + 14'd1;
    row_inc  = {1'b0, row_cur} + 13'd1;
    last_col = (col_inc >= stride);
    last_row = (row_inc >= rows);

    col_d    = col_q;
    row_d    = row_q;
    chroma_d = chroma_q;
    if (step_i) begin
      if (!last_col) begin
        col_d    = col_inc[nv12cb_pkg::ColW-1:0];
        row_d    = row_cur;
        chroma_d = chroma_cur;
      end else begin
        col_d = '0;
        if (!last_row) begin
          row_d    = row_inc[nv12cb_pkg::RowW-1:0];
          chroma_d = chroma_cur;
        end else begin
          row_d    = '0;
          chroma_d = ~chroma_cur;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      chroma_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      chroma_q <= chroma_d;
    end
  end

  assign pos_o.col      = col_cur;
  assign pos_o.chroma   = chroma_cur;
  assign pos_o.last_col = last_col;
  assign pos_o.last_row = last_row;

endmodule

FILE: hw/rtl/nv12cb_pixel.sv
module nv12cb_pixel (
  input  nv12cb_pkg::pos_t            pos_i,
  input  logic [nv12cb_pkg::DimW-1:0] width_i,
  output nv12cb_pkg::res_t            res_o
);

  logic [nv12cb_pkg::ColW-1:0] xb;
  logic [nv12cb_pkg::NumW-1:0] num;
  logic [nv12cb_pkg::NumW-1:0] thr [1:7];
  logic [nv12cb_pkg::BarW-1:0] bar;
  logic                        active;
  nv12cb_pkg::comp_e           comp;

  // bar = number of multiples k*w not above 8x
  always_comb begin
    xb  = pos_i.chroma ? {pos_i.col[nv12cb_pkg::ColW-1:1], 1'b0} : pos_i.col;
    num = {xb, 3'b000};
    bar = '0;
    for (int k = 1; k <= 7; k++) begin
      thr[k] = nv12cb_pkg::NumW'(width_i) * nv12cb_pkg::NumW'(k);
      if (num >= thr[k]) bar = bar + 3'd1;
    end
    active = ({1'b0, pos_i.col} < {1'b0, width_i});
    if (!pos_i.chroma)   comp = nv12cb_pkg::CompY;
    else if (pos_i.col[0]) comp = nv12cb_pkg::CompV;
    else                 comp = nv12cb_pkg::CompU;

    if (active)
      res_o.pixel_byte = nv12cb_pkg::bar_colour(bar, comp);
    else
      res_o.pixel_byte = pos_i.chroma ? nv12cb_pkg::ChromaPad : nv12cb_pkg::LumaPad;
    res_o.chroma_plane = pos_i.chroma;
    res_o.row_end      = pos_i.last_col;
    res_o.frame_end    = pos_i.last_col & pos_i.last_row & pos_i.chroma;
  end

endmodule

FILE: hw/rtl/nv12cb_out_skid.sv
module nv12cb_out_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  nv12cb_pkg::res_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output nv12cb_pkg::res_t out_data_o
);

  logic             out_valid_q, skid_valid_q;
  nv12cb_pkg::res_t out_q, skid_q;
  logic             in_beat;

  assign in_ready_o = ~skid_valid_q;
  assign in_beat    = in_valid_i & ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready_i || !out_valid_q) begin
      out_valid_q  <= skid_valid_q | in_beat;
      skid_valid_q <= 1'b0;
    end else if (in_beat) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (in_beat) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/nv12_color_bar_generator_core.sv
// NV12 colour bar pattern source, one byte per accepted input beat.
// Slave channel: s_axis_tdata[0] is the restart flag; a set flag starts a new
//   frame at luma row 0, column 0, otherwise the next byte of the frame follows.
// Master channel: tdata is the Y, U or V sample or padding byte, tuser[0] marks
//   the interleaved UV plane, tuser[1] the last byte of a row, tlast the last
//   byte of the frame (end of the UV plane).
// Configuration: cfg_index_i 0 width, 1 height, 2 luma stride, 3 chroma stride;
//   cfg_ready_o is always high. Writes apply from the next beat on.
// Each accepted beat's byte is registered. One beat is accepted every cycle
//   while s_axis_tready is high; position counters and the bar compare against the
//   seven multiples of the width sit between the input and the output register.
// A two-entry output buffer keeps s_axis_tready high for one more beat when the
//   receiver stalls, then drops it until the receiver takes the output beat.
// Reset clears the position to luma row 0, column 0 and loads 1920 x 1080 with
//   both strides at 1920.
module nv12_color_bar_generator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] pixel_byte
  output logic [1:0]  m_axis_tuser,   // [0] chroma_plane, [1] row_end
  output logic        m_axis_tlast,   // frame_end
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i
);

  logic [nv12cb_pkg::DimW-1:0]    width_q, height_q;
  logic [nv12cb_pkg::StrideW-1:0] luma_stride_q, chroma_stride_q;
  logic [nv12cb_pkg::DimW-1:0]    width_eff, height_eff;
  logic                           in_beat;
  nv12cb_pkg::pos_t               pos;
  nv12cb_pkg::res_t               res, res_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q         <= nv12cb_pkg::DefWidth;
      height_q        <= nv12cb_pkg::DefHeight;
      luma_stride_q   <= nv12cb_pkg::DefStride;
      chroma_stride_q <= nv12cb_pkg::DefStride;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        nv12cb_pkg::RegFrameWidth:   width_q         <= cfg_data_i[nv12cb_pkg::DimW-1:0];
        nv12cb_pkg::RegFrameHeight:  height_q        <= cfg_data_i[nv12cb_pkg::DimW-1:0];
        nv12cb_pkg::RegLumaStride:   luma_stride_q   <= cfg_data_i;
        nv12cb_pkg::RegChromaStride: chroma_stride_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign width_eff  = nv12cb_pkg::eff_width(width_q);
  assign height_eff = nv12cb_pkg::eff_height(height_q);
  assign in_beat    = s_axis_tvalid & s_axis_tready;

  nv12cb_counter u_counter (
    .clk_i,
    .rst_ni,
    .step_i          (in_beat),
    .restart_i       (s_axis_tdata[0]),
    .width_i         (width_eff),
    .height_i        (height_eff),
    .luma_stride_i   (luma_stride_q),
    .chroma_stride_i (chroma_stride_q),
    .pos_o           (pos)
  );

  nv12cb_pixel u_pixel (
    .pos_i   (pos),
    .width_i (width_eff),
    .res_o   (res)
  );

  nv12cb_out_skid u_out (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res_out)
  );

  assign m_axis_tdata = res_out.pixel_byte;
  assign m_axis_tuser = {res_out.row_end, res_out.chroma_plane};
  assign m_axis_tlast = res_out.frame_end;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit  = 400000;
  localparam int RandomBeats = 1200;
  localparam int HoldCycles  = 300;

  localparam logic [7:0] BarYuv [8][3] = '{
    '{8'd235, 8'd128, 8'd128},
    '{8'd210, 8'd16,  8'd146},
    '{8'd170, 8'd166, 8'd16},
    '{8'd145, 8'd54,  8'd34},
    '{8'd106, 8'd202, 8'd222},
    '{8'd81,  8'd90,  8'd240},
    '{8'd41,  8'd240, 8'd110},
    '{8'd16,  8'd128, 8'd128}
  };

  typedef enum bit {StepBeat, StepReg} step_kind_e;

  typedef struct packed {
    step_kind_e       kind;
    logic [1:0]       reg_idx;
    logic [13:0]      reg_val;
    logic             restart;
    logic             typed;
    nv12cb_pkg::res_t want;
  } script_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [13:0] cfg_data_i;

  nv12_color_bar_generator_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // own copy of the registers and the frame position
  logic [12:0] frame_w;
  logic [12:0] frame_h;
  logic [13:0] luma_pitch;
  logic [13:0] chroma_pitch;
  logic [12:0] col_pos;
  logic [11:0] row_pos;
  logic        uv_plane;

  nv12cb_pkg::res_t pending_bytes [$];
  int   mismatches;
  int   cycle_count;
  int   burst_left;
  bit   gaps_on;
  bit   hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** nv12_color_bar_generator_core: FAILED **");
      $finish;
    end
  end

  function automatic int unsigned bar_at(input int unsigned x, input int unsigned w);
    int unsigned b;
    b = (x * 8) / w;
    if (b > 7) b = 7;
    return b;
  endfunction

  function automatic nv12cb_pkg::res_t next_frame_byte(input logic restart);
    int unsigned w, h, pitch, rows, x;
    logic last_col, last_row;
    nv12cb_pkg::res_t r;
    w = (frame_w == '0) ? nv12cb_pkg::DefWidth : frame_w;
    if (w > nv12cb_pkg::MaxWidth) w = nv12cb_pkg::MaxWidth;
    h = (frame_h == '0) ? nv12cb_pkg::DefHeight : frame_h;
    if (h > nv12cb_pkg::MaxRows) h = nv12cb_pkg::MaxRows;
    if (restart) begin
      col_pos  = '0;
      row_pos  = '0;
      uv_plane = 1'b0;
    end
    pitch = uv_plane ? chroma_pitch : luma_pitch;
    if (pitch > nv12cb_pkg::MaxStride) pitch = nv12cb_pkg::MaxStride;
    if (pitch < w) pitch = w;
    rows = uv_plane ? (h + 1) / 2 : h;
    x = col_pos;
    if (!uv_plane) begin
      r.pixel_byte = (x < w) ? BarYuv[bar_at(x, w)][nv12cb_pkg::CompY] : nv12cb_pkg::LumaPad;
    end else if (x >= w) begin
      r.pixel_byte = nv12cb_pkg::ChromaPad;
    end else if (x % 2 == 0) begin
      r.pixel_byte = BarYuv[bar_at(x, w)][nv12cb_pkg::CompU];
    end else begin
      r.pixel_byte = BarYuv[bar_at(x - 1, w)][nv12cb_pkg::CompV];
    end
    last_col = (x + 1 >= pitch);
    last_row = (row_pos + 1 >= rows);
    r.chroma_plane = uv_plane;
    r.row_end      = last_col;
    r.frame_end    = last_col && last_row && uv_plane;
    if (!last_col) begin
      col_pos = col_pos + 13'd1;
    end else begin
      col_pos = '0;
      if (!last_row) begin
        row_pos = row_pos + 12'd1;
      end else begin
        row_pos  = '0;
        uv_plane = ~uv_plane;
      end
    end
    return r;
  endfunction

  // output side: compare every beat with the oldest pending byte
  always @(posedge clk_i) begin
    nv12cb_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_bytes.size() == 0) begin
        $error("output beat with no byte pending: tdata %0d", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (m_axis_tdata !== want.pixel_byte) begin
          $error("pixel_byte: expected %0d, got %0d", want.pixel_byte, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser[0] !== want.chroma_plane) begin
          $error("chroma_plane: expected %0d, got %0d", want.chroma_plane, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tuser[1] !== want.row_end) begin
          $error("row_end: expected %0d, got %0d", want.row_end, m_axis_tuser[1]);
          mismatches++;
        end
        if (m_axis_tlast !== want.frame_end) begin
          $error("frame_end: expected %0d, got %0d", want.frame_end, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode, span;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(4, 60);
        repeat (span) begin
          @(negedge clk_i);
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  task automatic offer_beat(input logic restart, input logic typed,
                            input nv12cb_pkg::res_t want);
    nv12cb_pkg::res_t predicted;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, restart};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = next_frame_byte(restart);
    pending_bytes.push_back(typed ? want : predicted);
    burst_left--;
  endtask

  task automatic settle_block();
    if (s_axis_tvalid) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      nv12cb_pkg::RegFrameWidth:   frame_w      = val[12:0];
      nv12cb_pkg::RegFrameHeight:  frame_h      = val[12:0];
      nv12cb_pkg::RegLumaStride:   luma_pitch   = val;
      nv12cb_pkg::RegChromaStride: chroma_pitch = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic script_row_t beat_row(input logic restart);
    return '{StepBeat, 2'd0, 14'd0, restart, 1'b0, nv12cb_pkg::res_t'(0)};
  endfunction

  function automatic script_row_t typed_row(input logic restart, input logic [7:0] pix,
                                            input logic plane, input logic re,
                                            input logic fe);
    nv12cb_pkg::res_t r;
    r = '{pix, plane, re, fe};
    return '{StepBeat, 2'd0, 14'd0, restart, 1'b1, r};
  endfunction

  function automatic script_row_t reg_row(input logic [1:0] idx, input logic [13:0] val);
    return '{StepReg, idx, val, 1'b0, 1'b0, nv12cb_pkg::res_t'(0)};
  endfunction

  function automatic logic [13:0] extreme_value(input logic [13:0] top);
    case ($urandom_range(0, 4))
      0:       return 14'd0;
      1:       return 14'd1;
      2:       return top;
      3:       return 14'd16383;
      default: return 14'($urandom_range(0, 16383));
    endcase
  endfunction

  initial begin
    script_row_t script [$];
    int beats_done, n, w;
    logic [13:0] ls, cs, h;
    logic restart;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    cycle_count   = 0;
    mismatches    = 0;
    burst_left    = 0;
    gaps_on       = 1'b1;
    hold_req      = 1'b0;
    frame_w       = nv12cb_pkg::DefWidth;
    frame_h       = nv12cb_pkg::DefHeight;
    luma_pitch    = nv12cb_pkg::DefStride;
    chroma_pitch  = nv12cb_pkg::DefStride;
    col_pos       = '0;
    row_pos       = '0;
    uv_plane      = 1'b0;

    // reset state, then a 1x1 frame, then 2x1 with raised chroma pitch
    script.push_back(typed_row(1'b0, 8'd235, 1'b0, 1'b0, 1'b0));
    script.push_back(typed_row(1'b1, 8'd235, 1'b0, 1'b0, 1'b0));
    script.push_back(beat_row(1'b0));
    script.push_back(reg_row(nv12cb_pkg::RegFrameWidth, 14'd1));
    script.push_back(reg_row(nv12cb_pkg::RegFrameHeight, 14'd1));
    script.push_back(reg_row(nv12cb_pkg::RegLumaStride, 14'd1));
    script.push_back(reg_row(nv12cb_pkg::RegChromaStride, 14'd1));
    script.push_back(typed_row(1'b1, 8'd235, 1'b0, 1'b1, 1'b0));
    script.push_back(typed_row(1'b0, 8'd128, 1'b1, 1'b1, 1'b1));
    script.push_back(typed_row(1'b0, 8'd235, 1'b0, 1'b1, 1'b0));
    script.push_back(reg_row(nv12cb_pkg::RegFrameWidth, 14'd2));
    script.push_back(reg_row(nv12cb_pkg::RegLumaStride, 14'd0));
    script.push_back(reg_row(nv12cb_pkg::RegChromaStride, 14'd3));
    script.push_back(typed_row(1'b1, 8'd235, 1'b0, 1'b0, 1'b0));
    script.push_back(typed_row(1'b0, 8'd106, 1'b0, 1'b1, 1'b0));
    script.push_back(typed_row(1'b0, 8'd128, 1'b1, 1'b0, 1'b0));
    script.push_back(typed_row(1'b0, 8'd128, 1'b1, 1'b0, 1'b0));
    script.push_back(typed_row(1'b0, 8'd128, 1'b1, 1'b1, 1'b1));
    // zero and oversized registers
    script.push_back(reg_row(nv12cb_pkg::RegFrameWidth, 14'd0));
    script.push_back(reg_row(nv12cb_pkg::RegFrameHeight, 14'd16383));
    script.push_back(reg_row(nv12cb_pkg::RegLumaStride, 14'd16383));
    script.push_back(reg_row(nv12cb_pkg::RegChromaStride, 14'd0));
    script.push_back(beat_row(1'b0));
    script.push_back(beat_row(1'b1));
    script.push_back(beat_row(1'b0));
    script.push_back(reg_row(nv12cb_pkg::RegFrameWidth, 14'd8191));
    script.push_back(beat_row(1'b1));
    script.push_back(beat_row(1'b0));
    script.push_back(beat_row(1'b0));
    script.push_back(reg_row(nv12cb_pkg::RegFrameWidth, 14'd4096));
    script.push_back(reg_row(nv12cb_pkg::RegFrameHeight, 14'd4096));
    script.push_back(reg_row(nv12cb_pkg::RegLumaStride, 14'd8192));
    script.push_back(reg_row(nv12cb_pkg::RegChromaStride, 14'd8192));
    script.push_back(beat_row(1'b1));
    script.push_back(beat_row(1'b0));
    // odd width with chroma tail
    script.push_back(reg_row(nv12cb_pkg::RegFrameWidth, 14'd7));
    script.push_back(reg_row(nv12cb_pkg::RegFrameHeight, 14'd3));
    script.push_back(reg_row(nv12cb_pkg::RegLumaStride, 14'd8));
    script.push_back(reg_row(nv12cb_pkg::RegChromaStride, 14'd9));
    script.push_back(beat_row(1'b1));
    script.push_back(beat_row(1'b0));
    script.push_back(beat_row(1'b0));
    script.push_back(beat_row(1'b0));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == StepReg) begin
        settle_block();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        offer_beat(script[i].restart, script[i].typed, script[i].want);
      end
    end

    beats_done = 0;
    for (int phase = 0; beats_done < RandomBeats; phase++) begin
      settle_block();
      if ($urandom_range(0, 7) == 0) begin
        write_reg(nv12cb_pkg::RegFrameWidth, extreme_value(14'(nv12cb_pkg::MaxWidth)));
        write_reg(nv12cb_pkg::RegFrameHeight, extreme_value(14'(nv12cb_pkg::MaxRows)));
        write_reg(nv12cb_pkg::RegLumaStride, extreme_value(nv12cb_pkg::MaxStride));
        write_reg(nv12cb_pkg::RegChromaStride, extreme_value(nv12cb_pkg::MaxStride));
      end else begin
        w  = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        h  = 14'($urandom_range(1, 6));
        ls = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, w))
                                          : 14'(w + $urandom_range(0, 6));
        cs = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, w))
                                          : 14'(w + $urandom_range(0, 6));
        write_reg(nv12cb_pkg::RegFrameWidth, 14'(w));
        write_reg(nv12cb_pkg::RegFrameHeight, h);
        write_reg(nv12cb_pkg::RegLumaStride, ls);
        write_reg(nv12cb_pkg::RegChromaStride, cs);
      end
      n = $urandom_range(30, 150);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (phase == 1) begin
        // long receiver hold-off while the sender keeps offering
        hold_req = 1'b1;
        gaps_on  = 1'b0;
        n = 200;
      end
      for (int i = 0; i < n; i++) begin
        restart = (i == 0 && $urandom_range(0, 2) == 0) || ($urandom_range(0, 63) == 0);
        offer_beat(restart, 1'b0, nv12cb_pkg::res_t'(0));
        beats_done++;
      end
    end

    settle_block();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("** nv12_color_bar_generator_core: PASSED **");
    end else begin
      $display("** nv12_color_bar_generator_core: FAILED **");
    end
    $finish;
  end

endmodule
